// File: src/rdc_pkg.sv
// rdc_pkg: shared constants, types and the digit glyph function for the
// radix digit converter. No dependencies.
package rdc_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 32;

    // field widths
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    // radix register reset and valid range
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ascii codes of the first numeral and first letter glyphs
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_ERR  = 7'h00;
    localparam logic [DIGIT_W-1:0] TEN      = 4'd10;

    // quotient bits retired per divider cycle
    localparam int DIV_STEPS = 8;

    // queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    // control part of one request between front and back
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               bad;
    } rdc_ctl_t;

    // one result item
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
        logic              bad_radix;
    } rdc_result_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_ERR,
        BK_EMIT
    } rdc_back_state_t;

    // lower-case ascii glyph of a digit
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < TEN)
        begin
            res = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            res = CHAR_A + {3'b000, d - TEN};
        end
        return res;
    endfunction

endpackage

// File: src/rdc_front.sv
// rdc_front: input side of the converter; holds the radix register and
// classifies each request. Depends on rdc_pkg.
module rdc_front
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_radix,
    input  logic               q_full,
    output logic               q_push,
    output rdc_ctl_t           q_ctl
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;

    // configuration register, always ready
    assign cfg_ready  = 1'b1;
    assign radix_next = (cfg_valid && cfg_ready) ? cfg_radix : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // request acceptance follows the command queue
    assign full   = q_full;
    assign q_push = push && !q_full;

    // classify the base
    always_comb
    begin
        q_ctl.radix = radix_reg;
        q_ctl.bad   = !(radix_reg inside {[RADIX_MIN:RADIX_MAX]});
    end

endmodule

// File: src/rdc_cmd_queue.sv
// rdc_cmd_queue: short request queue between front and back end.
// Depends on rdc_pkg.
module rdc_cmd_queue
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_push,
    input  logic [VALUE_BITS-1:0] in_value,
    input  rdc_ctl_t              in_ctl,
    output logic                  q_full,
    input  logic                  out_pop,
    output logic                  out_valid,
    output logic [VALUE_BITS-1:0] out_value,
    output rdc_ctl_t              out_ctl
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    logic [VALUE_BITS-1:0] value_mem [CMDQ_DEPTH];
    rdc_ctl_t              ctl_mem   [CMDQ_DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         rd_ptr_reg;
    logic [CW-1:0]         count_reg;
    logic [PW-1:0]         wr_ptr_next;
    logic [PW-1:0]         rd_ptr_next;
    logic [CW-1:0]         count_next;
    logic                  wr_en;
    logic                  rd_en;

    assign q_full    = (count_reg == CW'(CMDQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign wr_en     = in_push && !q_full;
    assign rd_en     = out_pop && out_valid;
    assign out_value = value_mem[rd_ptr_reg];
    assign out_ctl   = ctl_mem[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_ptr_reg] <= in_value;
            ctl_mem[wr_ptr_reg]   <= in_ctl;
        end
    end

endmodule

// File: src/rdc_back.sv
// rdc_back: back end of the converter; iterative divider, digit store and
// most-significant-first digit emission into a small result queue.
// Depends on rdc_pkg.
module rdc_back
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  logic [VALUE_BITS-1:0] cmd_value,
    input  rdc_ctl_t              cmd_ctl,
    output logic                  cmd_pop,
    output logic                  empty,
    input  logic                  pop,
    output rdc_result_t           result
);

    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QW         = DIV_CYCLES * DIV_STEPS;
    localparam int SW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int AW         = $clog2(MAX_DIGITS);
    localparam int OPW        = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int OCW        = $clog2(OUTQ_DEPTH + 1);

    rdc_back_state_t     state_reg;
    rdc_back_state_t     state_next;

    logic [QW-1:0]       q_reg;
    logic [QW-1:0]       q_next;
    logic [DIGIT_W-1:0]  rem_reg;
    logic [DIGIT_W-1:0]  rem_next;
    logic [RADIX_W-1:0]  radix_reg;
    logic [SW-1:0]       step_reg;
    logic [AW-1:0]       n_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic [DIGIT_W-1:0]  store_mem [MAX_DIGITS];

    logic                pend_valid_reg;
    logic                pend_last_reg;
    logic                pend_bad_reg;

    rdc_result_t         outq_mem [OUTQ_DEPTH];
    logic [OPW-1:0]      owr_ptr_reg;
    logic [OPW-1:0]      ord_ptr_reg;
    logic [OCW-1:0]      ocount_reg;

    logic                last_step;
    logic                quot_zero;
    logic                div_done;
    logic                slot_free;
    logic                issue;
    logic                issue_err;
    logic                mem_we;
    logic                mem_re;
    logic                out_push;
    logic                out_pop;
    rdc_result_t         out_entry;

    // divider slice: several restoring steps on the narrow remainder
    always_comb
    begin
        logic [RADIX_W-1:0]   t;
        logic [DIGIT_W-1:0]   r;
        logic [DIV_STEPS-1:0] bits;
        r    = rem_reg;
        bits = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, q_reg[QW-1-i]};
            if (t >= radix_reg)
            begin
                t                   = t - radix_reg;
                bits[DIV_STEPS-1-i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_next = r;
        q_next   = (q_reg << DIV_STEPS) | QW'(bits);
    end

    assign last_step = (step_reg == SW'(DIV_CYCLES - 1));
    assign quot_zero = (q_next == '0);
    assign div_done  = last_step && (quot_zero || (n_reg == AW'(MAX_DIGITS - 1)));
    assign slot_free = ({1'b0, ocount_reg} + {{OCW{1'b0}}, pend_valid_reg})
                       < (OCW + 1)'(OUTQ_DEPTH);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cmd_ctl.bad ? BK_ERR : BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_ERR:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                if (slot_free && (rd_addr_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_pop   = 1'b0;
        issue     = 1'b0;
        issue_err = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            BK_DIV:
            begin
                mem_we = last_step;
            end
            BK_ERR:
            begin
                issue     = slot_free;
                issue_err = slot_free;
            end
            BK_EMIT:
            begin
                issue  = slot_free;
                mem_re = slot_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            step_reg       <= '0;
            n_reg          <= '0;
            rd_addr_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= issue;
            if (issue)
            begin
                pend_last_reg <= issue_err || (rd_addr_reg == '0);
                pend_bad_reg  <= issue_err;
            end
            if (cmd_pop)
            begin
                step_reg <= '0;
                n_reg    <= '0;
            end
            else if (state_reg == BK_DIV)
            begin
                step_reg <= last_step ? '0 : step_reg + 1'b1;
                if (last_step && !div_done)
                begin
                    n_reg <= n_reg + 1'b1;
                end
                if (div_done)
                begin
                    rd_addr_reg <= n_reg;
                end
            end
            else if (mem_re)
            begin
                rd_addr_reg <= rd_addr_reg - 1'b1;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            q_reg     <= QW'(cmd_value);
            rem_reg   <= '0;
            radix_reg <= cmd_ctl.radix;
        end
        else if (state_reg == BK_DIV)
        begin
            q_reg   <= q_next;
            rem_reg <= last_step ? '0 : rem_next;
        end
    end

    // digit store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[n_reg] <= rem_next;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    // result queue
    always_comb
    begin
        out_entry.digit_char = pend_bad_reg ? CHAR_ERR : glyph(rd_data_reg);
        out_entry.last_digit = pend_last_reg;
        out_entry.bad_radix  = pend_bad_reg;
    end

    assign out_push = pend_valid_reg;
    assign empty    = (ocount_reg == '0);
    assign out_pop  = pop && !empty;
    assign result   = outq_mem[ord_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            if (out_push)
            begin
                owr_ptr_reg <= (owr_ptr_reg == OPW'(OUTQ_DEPTH - 1)) ? '0 : owr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                ord_ptr_reg <= (ord_ptr_reg == OPW'(OUTQ_DEPTH - 1)) ? '0 : ord_ptr_reg + 1'b1;
            end
            if (out_push && !out_pop)
            begin
                ocount_reg <= ocount_reg + 1'b1;
            end
            else if (out_pop && !out_push)
            begin
                ocount_reg <= ocount_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            outq_mem[owr_ptr_reg] <= out_entry;
        end
    end

endmodule

// File: src/radix_digit_converter_core.sv
// radix_digit_converter_core: top level of the radix digit converter.
// Depends on rdc_pkg, rdc_front, rdc_cmd_queue and rdc_back.
//
// Usage: write the base on the configuration channel (cfg_valid/cfg_ready,
// cfg_radix) while the block is idle; it resets to base 2. Values go in on
// the push/full side. For each value the block returns its digits, most
// significant first, on the empty/pop side as lower-case ascii in
// digit_char, with last_digit set on the least significant digit. A base
// outside 2..16 gives one result with digit_char 0, last_digit and
// bad_radix set. Zero gives the single digit '0'.
// Rate: one value is converted at a time by an iterative
// divider that retires 8 quotient bits a cycle, and the digits then go
// out from the registered digit store.
// A two-entry request queue lets the next value wait while one converts.
// Reset clears all queues and the sequencer; the digit store needs no
// clearing. When the receiver stalls, the two-entry result queue fills and
// emission pauses; no result is lost.
module radix_digit_converter_core
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_W-1:0]    cfg_radix,
    output logic                  empty,
    input  logic                  pop,
    output logic [CHAR_W-1:0]     digit_char,
    output logic                  last_digit,
    output logic                  bad_radix
);

    logic                  q_full;
    logic                  q_push;
    rdc_ctl_t              q_ctl;
    logic                  cmd_valid;
    logic                  cmd_pop;
    logic [VALUE_BITS-1:0] cmd_value;
    rdc_ctl_t              cmd_ctl;
    rdc_result_t           result;

    // front end: radix register and request classification
    rdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_radix (cfg_radix),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctl     (q_ctl)
    );

    // request queue between the two halves
    rdc_cmd_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (q_push),
        .in_value  (value),
        .in_ctl    (q_ctl),
        .q_full    (q_full),
        .out_pop   (cmd_pop),
        .out_valid (cmd_valid),
        .out_value (cmd_value),
        .out_ctl   (cmd_ctl)
    );

    // back end: division, digit store and emission
    rdc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_value (cmd_value),
        .cmd_ctl   (cmd_ctl),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign digit_char = result.digit_char;
    assign last_digit = result.last_digit;
    assign bad_radix  = result.bad_radix;

endmodule
